// File: hw/rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// LFU slot replacement package
// Shared types and constants for the LFU slot replacement core.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

    // Field widths of the request and result.
    localparam int PART_W     = 10;
    localparam int TAG_W      = 7;
    localparam int ACTION_W   = 2;
    localparam int SLOT_OUT_W = 3;

    // Stream payload widths, padded to whole bytes.
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 16;
    localparam int S_PAD_W    = S_DATA_W - PART_W;
    localparam int M_PAD_W    = M_DATA_W - ACTION_W - SLOT_OUT_W - TAG_W;

    // Division by ten as a multiply by a reciprocal: exact for inputs below 1029.
    localparam int BIN_MUL_W  = 8;
    localparam int PROD_W     = PART_W + BIN_MUL_W;
    localparam int BIN_SHIFT  = 11;
    localparam logic [BIN_MUL_W-1:0] BIN_MUL = 8'd205;

    // Result action codes.
    localparam logic [ACTION_W-1:0] ACT_HIT     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FILL    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REPLACE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_UPDATE,
        ST_MOVE,
        ST_CLOSE
    } lfu_state_t;

    // Sequencer to datapath.
    typedef struct packed {
        logic ready;
        logic do_scan;
        logic do_pick;
        logic do_update;
        logic do_move;
        logic do_close;
    } lfu_ctrl_t;

    // Datapath to sequencer.
    typedef struct packed {
        logic req_accept;
        logic resolved;
        logic out_free;
    } lfu_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/lfu_slot_replacement_core.sv
// ----------------------------------------------------------------------------
// LFU slot replacement core
// Fully associative bin store with least-frequently-used replacement and
// protection of the most recently used slots.
// ----------------------------------------------------------------------------
// Usage: each request on the s_ channel carries a part number; its bin is the
// part number divided by ten. For every request one result leaves on the m_
// channel: the action taken (hit, fill of a free slot, or replacement), the
// slot that now holds the bin, and the evicted bin on a replacement.
// All work runs through one shared comparator under a sequencer, so a request
// passes through a tag scan over all slots, a recency move over all slots, one
// update step and one hand-over step. A replacement adds a victim pick over
// each candidate (NUM_SLOTS minus the protected count). m_tvalid and s_tready
// rise at the same edge, so a new request is taken only after the previous
// result has been handed over to the output register.
// s_tready is high only while the core is idle. A result waits in the output
// register until taken; if the previous result is still held there, the
// hand-over step waits, and no new request is accepted meanwhile.
// Reset empties all slots, clears the use counts, puts the recency list in
// slot order and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_slot_replacement_core import lfu_pkg::*; #(
    parameter int NUM_SLOTS        = 5,
    parameter int COUNT_BITS       = 16,
    parameter int PROTECTED_RECENT = 3
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // part_number[9:0], zero pad
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata    // action[1:0], slot_used[4:2],
                                                // evicted_bin[11:5], zero pad
);

    localparam int IDX_W    = $clog2(NUM_SLOTS);
    localparam int PROT_EFF = (PROTECTED_RECENT > NUM_SLOTS - 1) ? NUM_SLOTS - 1
                                                                : PROTECTED_RECENT;
    localparam int CANDS    = NUM_SLOTS - PROT_EFF;
    localparam int CMP_W    = (COUNT_BITS > TAG_W) ? COUNT_BITS : TAG_W;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(NUM_SLOTS - 1);

    lfu_ctrl_t         ctrl;
    lfu_status_t       status;
    logic [IDX_W-1:0]  idx;

    // Slot store.
    logic [TAG_W-1:0]      tag_mem   [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  valid_reg;
    logic [COUNT_BITS-1:0] count_reg [NUM_SLOTS];
    logic [IDX_W-1:0]      rec_reg   [NUM_SLOTS];

    // Per-request working registers.
    logic [TAG_W-1:0]      bin_reg;
    logic                  hit_found_reg, free_found_reg;
    logic [IDX_W-1:0]      hit_slot_reg, free_slot_reg, best_slot_reg;
    logic [COUNT_BITS-1:0] best_cnt_reg;
    logic [IDX_W-1:0]      slot_reg;
    logic [ACTION_W-1:0]   action_reg;
    logic [TAG_W-1:0]      evict_reg;
    logic                  seen_reg;

    // Output register.
    logic                  m_tvalid_reg;
    logic [M_DATA_W-1:0]   m_tdata_reg;

    logic                  req_accept;
    logic [PROD_W-1:0]     bin_prod;
    logic [IDX_W-1:0]      upd_slot, tag_addr, cnt_addr, rec_rd, idx_prev;
    logic [TAG_W-1:0]      tag_rd;
    logic [COUNT_BITS-1:0] cnt_rd;
    logic [CMP_W-1:0]      cmp_a, cmp_b;
    logic                  cmp_eq, cmp_lt;
    logic                  hit_now, free_now, take_cand;
    logic [ACTION_W-1:0]   upd_action;

    assign req_accept = s_tvalid && s_tready;
    assign s_tready   = ctrl.ready;
    assign bin_prod   = PROD_W'(s_tdata[PART_W-1:0]) * PROD_W'(BIN_MUL);

    assign upd_slot = hit_found_reg  ? hit_slot_reg  :
                      free_found_reg ? free_slot_reg : best_slot_reg;
    assign upd_action = hit_found_reg  ? ACT_HIT  :
                        free_found_reg ? ACT_FILL : ACT_REPLACE;

    assign rec_rd   = rec_reg[idx];
    assign tag_addr = ctrl.do_scan ? idx : upd_slot;
    assign cnt_addr = ctrl.do_pick ? rec_rd : upd_slot;
    assign tag_rd   = tag_mem[tag_addr];
    assign cnt_rd   = count_reg[cnt_addr];
    assign idx_prev = idx - 1'b1;

    // Operand selection for the shared comparator.
    always_comb begin
        cmp_a = CMP_W'(tag_rd);
        cmp_b = CMP_W'(bin_reg);
        if (ctrl.do_pick) begin
            cmp_a = CMP_W'(cnt_rd);
            cmp_b = CMP_W'(best_cnt_reg);
        end else if (ctrl.do_move) begin
            cmp_a = CMP_W'(rec_rd);
            cmp_b = CMP_W'(slot_reg);
        end
    end

    lfu_cmp #(.WIDTH(CMP_W)) u_cmp (
        .op_a   (cmp_a),
        .op_b   (cmp_b),
        .a_eq_b (cmp_eq),
        .a_lt_b (cmp_lt)
    );

    assign hit_now  = valid_reg[idx] && cmp_eq;
    assign free_now = !valid_reg[idx];
    // The first candidate is always taken; later ones on a smaller count, or
    // on an equal count with a lower slot number.
    assign take_cand = (idx == '0) || cmp_lt || (cmp_eq && (rec_rd < best_slot_reg));

    assign status.req_accept = req_accept;
    assign status.resolved   = hit_found_reg || free_found_reg || hit_now || free_now;
    assign status.out_free   = !m_tvalid_reg || m_tready;

    lfu_seq #(
        .NUM_SLOTS (NUM_SLOTS),
        .CANDS     (CANDS),
        .IDX_W     (IDX_W)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl),
        .idx     (idx)
    );

    // Tag store: no reset, only read where the valid bit is set.
    always_ff @(posedge aclk) begin
        if (ctrl.do_update && !hit_found_reg) tag_mem[upd_slot] <= bin_reg;
    end

    // Valid bits, use counts and recency list.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                count_reg[i] <= '0;
                rec_reg[i]   <= IDX_W'(i);
            end
        end else begin
            if (ctrl.do_update) begin
                if (hit_found_reg) begin
                    if (cnt_rd != '1) count_reg[upd_slot] <= cnt_rd + 1'b1;
                end else begin
                    valid_reg[upd_slot] <= 1'b1;
                    count_reg[upd_slot] <= COUNT_BITS'(1);
                end
            end
            // Entries behind the used slot shift down one place, one per cycle.
            if (ctrl.do_move && seen_reg) rec_reg[idx_prev] <= rec_rd;
            if (ctrl.do_close) rec_reg[LAST_SLOT] <= slot_reg;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            seen_reg       <= 1'b0;
        end else begin
            if (req_accept) begin
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end
            if (ctrl.do_scan) begin
                if (hit_now && !hit_found_reg) begin
                    hit_found_reg <= 1'b1;
                    hit_slot_reg  <= idx;
                end
                if (free_now && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                    free_slot_reg  <= idx;
                end
            end
            if (ctrl.do_update) seen_reg <= 1'b0;
            else if (ctrl.do_move && cmp_eq) seen_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (req_accept) bin_reg <= bin_prod[BIN_SHIFT +: TAG_W];
        if (ctrl.do_pick && take_cand) begin
            best_slot_reg <= rec_rd;
            best_cnt_reg  <= cnt_rd;
        end
        if (ctrl.do_update) begin
            slot_reg   <= upd_slot;
            action_reg <= upd_action;
            evict_reg  <= (upd_action == ACT_REPLACE) ? tag_rd : '0;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.do_close && status.out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.do_close && status.out_free) begin
            m_tdata_reg <= {{M_PAD_W{1'b0}}, evict_reg, SLOT_OUT_W'(slot_reg), action_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/lfu_cmp.sv
// ----------------------------------------------------------------------------
// LFU shared comparator
// Equality and unsigned less-than on one pair of operands, shared by the
// scan, pick and move steps of the sequencer: tag match, count minimum and recency search.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cmp #(
    parameter int WIDTH = 16
) (
    input  wire logic [WIDTH-1:0] op_a,
    input  wire logic [WIDTH-1:0] op_b,
    output logic                  a_eq_b,
    output logic                  a_lt_b
);

    assign a_eq_b = (op_a == op_b);
    assign a_lt_b = (op_a < op_b);

endmodule

`default_nettype wire

// File: hw/rtl/lfu_seq.sv
// ----------------------------------------------------------------------------
// LFU sequencer
// Steps one request through scan, victim pick, update, recency move and
// result hand-over, with a slot counter for the iterative phases.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_seq import lfu_pkg::*; #(
    parameter int NUM_SLOTS = 5,
    parameter int CANDS     = 2,
    parameter int IDX_W     = 3
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire lfu_status_t      status,
    output lfu_ctrl_t             ctrl,
    output logic [IDX_W-1:0]      idx
);

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(NUM_SLOTS - 1);
    localparam logic [IDX_W-1:0] LAST_CAND = IDX_W'(CANDS - 1);

    lfu_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              idx_last;
    logic              advance;

    always_comb begin
        case (state_reg)
            ST_PICK: idx_last = (idx_reg == LAST_CAND);
            default: idx_last = (idx_reg == LAST_SLOT);
        endcase
    end

    assign advance = (state_reg == ST_SCAN) || (state_reg == ST_PICK) ||
                     (state_reg == ST_MOVE);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (status.req_accept) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (idx_last) state_next = status.resolved ? ST_UPDATE : ST_PICK;
            end
            ST_PICK: begin
                if (idx_last) state_next = ST_UPDATE;
            end
            ST_UPDATE: state_next = ST_MOVE;
            ST_MOVE: begin
                if (idx_last) state_next = ST_CLOSE;
            end
            ST_CLOSE: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        ctrl = '0;
        case (state_reg)
            ST_IDLE:   ctrl.ready     = 1'b1;
            ST_SCAN:   ctrl.do_scan   = 1'b1;
            ST_PICK:   ctrl.do_pick   = 1'b1;
            ST_UPDATE: ctrl.do_update = 1'b1;
            ST_MOVE:   ctrl.do_move   = 1'b1;
            ST_CLOSE:  ctrl.do_close  = 1'b1;
            default:   ctrl = '0;
        endcase
    end

    assign idx_next = (advance && !idx_last) ? idx_reg + 1'b1 : '0;
    assign idx      = idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lfu_checker.sv
// ----------------------------------------------------------------------------
// LFU port checker
// Concurrent assertions on the ports of the LFU slot replacement core.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_checker import lfu_pkg::*; #(
    parameter int NUM_SLOTS = 5
) (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    logic [ACTION_W-1:0]   chk_action;
    logic [SLOT_OUT_W-1:0] chk_slot;
    logic [TAG_W-1:0]      chk_evict;

    assign chk_action = m_tdata[ACTION_W-1:0];
    assign chk_slot   = m_tdata[ACTION_W +: SLOT_OUT_W];
    assign chk_evict  = m_tdata[ACTION_W + SLOT_OUT_W +: TAG_W];

    // A held result stays unchanged until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The core works on one request at a time; an earlier result may still wait.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("core not busy after accepting a request");

    a_action_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (chk_action == ACT_HIT) || (chk_action == ACT_FILL) ||
                     (chk_action == ACT_REPLACE))
        else $error("undefined action code");

    a_evict_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (chk_action != ACT_REPLACE) |-> (chk_evict == '0))
        else $error("evicted bin set without a replacement");

    a_data_zero_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_DATA_W-1:ACTION_W + SLOT_OUT_W + TAG_W] == '0) &&
                     ((NUM_SLOTS > 8) || (32'(chk_slot) < NUM_SLOTS)))
        else $error("result padding or slot number out of range");

endmodule

bind lfu_slot_replacement_core lfu_checker #(
    .NUM_SLOTS (NUM_SLOTS)
) u_lfu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: dv/lfu_slot_replacement_core_tb.sv
// ----------------------------------------------------------------------------
// LFU slot replacement core testbench
// Sends part-number requests into the core and predicts the action, slot and
// evicted bin of every result. The prediction tracks the slot tags, use counts
// and recency list. A directed opening is followed by random traffic drawn
// mostly from small working sets of bins, under several sender and receiver
// idling patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_slot_replacement_core_tb;

    import lfu_pkg::*;

    localparam int NUM_SLOTS        = 5;
    localparam int COUNT_BITS       = 16;
    localparam int PROTECTED_RECENT = 3;
    localparam int BIN_DIVISOR      = 10;
    localparam int PART_MAX         = (1 << PART_W) - 1;
    localparam int LAST_BIN         = PART_MAX / BIN_DIVISOR;
    localparam longint COUNT_MAX    = (64'd1 << COUNT_BITS) - 1;
    localparam int ITEMS_PER_PHASE  = 475;
    localparam int DRAIN_CYCLES     = 40;

    typedef struct packed {
        logic [TAG_W-1:0]      evicted_bin;
        logic [SLOT_OUT_W-1:0] slot_used;
        logic [ACTION_W-1:0]   action;
    } slot_result_t;

    // Tracks the slot store and keeps the outcomes still owed by the core.
    class lfu_scoreboard;
        logic [TAG_W-1:0] bin_tag [NUM_SLOTS];
        bit               occupied [NUM_SLOTS];
        longint           use_count [NUM_SLOTS];
        int               recency [NUM_SLOTS];
        slot_result_t     owed_results [$];
        int               mismatches;
        int               n_hit;
        int               n_fill;
        int               n_replace;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++) begin
                occupied[i]  = 1'b0;
                use_count[i] = 0;
                recency[i]   = i;
                bin_tag[i]   = '0;
            end
            mismatches = 0;
            n_hit      = 0;
            n_fill     = 0;
            n_replace  = 0;
        endfunction

        function int choose_victim();
            int  spared;
            int  best;
            bit  have;
            int  s;
            spared = PROTECTED_RECENT;
            if (spared > NUM_SLOTS - 1)
                spared = NUM_SLOTS - 1;
            best = 0;
            have = 1'b0;
            // Only the least recent positions below the protected band compete.
            for (int i = 0; i < NUM_SLOTS - spared; i++) begin
                s = recency[i];
                if (!have || use_count[s] < use_count[best] ||
                    (use_count[s] == use_count[best] && s < best)) begin
                    best = s;
                    have = 1'b1;
                end
            end
            return best;
        endfunction

        function void note_request(logic [PART_W-1:0] part);
            logic [TAG_W-1:0] bin;
            int               slot;
            int               pos;
            bit               found;
            slot_result_t     res;
            bin   = TAG_W'(int'(part) / BIN_DIVISOR);
            slot  = 0;
            found = 1'b0;
            res   = '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (!found && occupied[i] && bin_tag[i] == bin) begin
                    slot  = i;
                    found = 1'b1;
                end
            end
            if (found) begin
                res.action = ACT_HIT;
                if (use_count[slot] < COUNT_MAX)
                    use_count[slot]++;
                n_hit++;
            end else begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!found && !occupied[i]) begin
                        slot  = i;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    res.action = ACT_FILL;
                    n_fill++;
                end else begin
                    res.action      = ACT_REPLACE;
                    slot            = choose_victim();
                    res.evicted_bin = bin_tag[slot];
                    n_replace++;
                end
                bin_tag[slot]   = bin;
                occupied[slot]  = 1'b1;
                use_count[slot] = 1;
            end
            pos = 0;
            for (int i = NUM_SLOTS - 1; i >= 0; i--)
                if (recency[i] == slot)
                    pos = i;
            for (int i = pos; i < NUM_SLOTS - 1; i++)
                recency[i] = recency[i + 1];
            recency[NUM_SLOTS - 1] = slot;
            res.slot_used = SLOT_OUT_W'(slot);
            owed_results.push_back(res);
        endfunction

        task report_mismatch(string what, int got, int want);
            mismatches++;
            $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        endtask

        task check_result(logic [M_DATA_W-1:0] data);
            slot_result_t got;
            slot_result_t want;
            got = data[ACTION_W+SLOT_OUT_W+TAG_W-1:0];
            if (owed_results.size() == 0) begin
                report_mismatch("unrequested result, action", got.action, -1);
            end else begin
                want = owed_results.pop_front();
                if (got.action != want.action)
                    report_mismatch("action", got.action, want.action);
                if (got.slot_used != want.slot_used)
                    report_mismatch("slot_used", got.slot_used, want.slot_used);
                if (got.evicted_bin != want.evicted_bin)
                    report_mismatch("evicted_bin", got.evicted_bin, want.evicted_bin);
            end
        endtask

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    int                  sender_idle_pct;
    int                  recv_stall_pct;
    int                  working_bins [7];
    lfu_scoreboard       sb;

    lfu_slot_replacement_core #(
        .NUM_SLOTS        (NUM_SLOTS),
        .COUNT_BITS       (COUNT_BITS),
        .PROTECTED_RECENT (PROTECTED_RECENT)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_part(input logic [PART_W-1:0] part);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(part);
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_request(part);
        @(negedge aclk);
    endtask

    task automatic pick_working_bins();
        for (int i = 0; i < 7; i++)
            working_bins[i] = $urandom_range(0, LAST_BIN);
    endtask

    // Mostly requests from a small set of bins so that hits and replacements
    // dominate; the rest are spread over the whole part-number range.
    task automatic send_random_part();
        int part;
        if ($urandom_range(99) < 80) begin
            part = working_bins[$urandom_range(0, 6)] * BIN_DIVISOR +
                   $urandom_range(0, BIN_DIVISOR - 1);
            if (part > PART_MAX)
                part = PART_MAX;
        end else begin
            part = $urandom_range(0, PART_MAX);
        end
        send_part(PART_W'(part));
    endtask

    initial begin
        int directed_parts [];

        // Hit early, fill every slot, then force replacements among low and high
        // bins, with tied and unequal use counts.
        directed_parts = '{0, 9, 1023, 1000, 999, 512, 1010, 1021, 5, 7,
                           345, 682, 341, 1022, 1, 2, 1019, 330, 678,
                           1023, 0, 999, 1015, 512};

        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        sb              = new();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_parts[i])
            send_part(PART_W'(directed_parts[i]));

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin sender_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 60 == 0)
                    pick_working_bins();
                send_random_part();
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Requests: %0d hits, %0d fills, %0d replacements",
                 sb.n_hit, sb.n_fill, sb.n_replace);
        $display("Idling patterns covered: none, sender, receiver, both");
        if (sb.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2_400_000;
        $display("Timeout with %0d results outstanding", sb.pending());
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
